### hw/rtl/tfrhs_pkg.sv
// Shared types, constants and the micro-op tables of the thin film rate stencil.
// No dependencies; used by the controller, datapath and top level.
package tfrhs_pkg;

  // widest address the depth range needs, and fixed payload widths
  localparam int ADDR_W  = 12;
  localparam int INDEX_W = 6;
  localparam int CFG_W   = 32;

  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

  // configuration register indexes
  localparam logic CFG_INV_SPACING    = 1'b0;
  localparam logic CFG_PRECURSOR_POW6 = 1'b1;

  typedef enum logic [3:0] {
    OP_CLR = 4'd0, OP_RDH = 4'd1, OP_RDP = 4'd2, OP_WRP = 4'd3, OP_MUL = 4'd4,
    OP_DIV = 4'd5, OP_SUB = 4'd6, OP_NEG = 4'd7, OP_OUT = 4'd8, OP_DV3 = 4'd9
  } op_t;

  typedef enum logic [4:0] {
    SRC_A = 5'd0, SRC_B = 5'd1, SRC_C = 5'd2, SRC_D = 5'd3,
    SRC_PM = 5'd4, SRC_PK = 5'd5, SRC_PN = 5'd6, SRC_HC = 5'd7,
    SRC_INV = 5'd8, SRC_L6 = 5'd9, SRC_HSUM = 5'd10, SRC_HC2 = 5'd11,
    SRC_MIDP = 5'd12, SRC_MIDM = 5'd13, SRC_ONE32 = 5'd14, SRC_TWO60 = 5'd15,
    SRC_THREE = 5'd16, SRC_RECIP3 = 5'd17
  } src_t;

  typedef enum logic [3:0] {
    DST_A = 4'd0, DST_B = 4'd1, DST_C = 4'd2, DST_D = 4'd3,
    DST_HM = 4'd4, DST_HC = 4'd5, DST_HP = 4'd6,
    DST_PM = 4'd7, DST_PK = 4'd8, DST_PN = 4'd9
  } dst_t;

  typedef enum logic [2:0] {
    SH0 = 3'd0, SH16 = 3'd1, SH24 = 3'd2, SH28 = 3'd3,
    SH32 = 3'd4, SH40 = 3'd5, SH52 = 3'd6, SH56 = 3'd7
  } sh_t;

  typedef enum logic [1:0] {
    NB_PREV = 2'd0, NB_CUR = 2'd1, NB_NEXT = 2'd2
  } nb_t;

  typedef struct packed {
    op_t  op;
    src_t a;
    src_t b;
    dst_t dst;
    sh_t  sh;
    logic asgn;   // operand a is signed
    logic rsgn;   // result clamps to the signed range
    nb_t  nb;     // which neighbour a memory op addresses
    logic fin;    // last op of the program
  } uop_t;

  // command from controller to datapath
  typedef struct packed {
    logic                start;
    logic                load_we;
    logic [ADDR_W-1:0]   addr;
    logic [INDEX_W-1:0]  pt_index;
    logic                last;
    op_t                 op;
    src_t                a;
    src_t                b;
    dst_t                dst;
    sh_t                 sh;
    logic                asgn;
    logic                rsgn;
  } cmd_t;

  typedef struct packed {
    logic done;
  } status_t;

  function automatic uop_t mk(op_t op, src_t a, src_t b, dst_t dst, sh_t sh,
                              logic asgn, logic rsgn, nb_t nb, logic fin);
    uop_t u;
    u.op = op; u.a = a; u.b = b; u.dst = dst; u.sh = sh;
    u.asgn = asgn; u.rsgn = rsgn; u.nb = nb; u.fin = fin;
    return u;
  endfunction

  // pressure program, one pass per stored point
  function automatic uop_t press_uop(logic [4:0] pc);
    uop_t u;
    unique case (pc)
      5'd0:  u = mk(OP_CLR, SRC_A, SRC_A, DST_A, SH0, 1'b0, 1'b0, NB_CUR, 1'b0);
      5'd1:  u = mk(OP_RDH, SRC_A, SRC_A, DST_HM, SH0, 1'b0, 1'b0, NB_PREV, 1'b0);
      5'd2:  u = mk(OP_RDH, SRC_A, SRC_A, DST_HC, SH0, 1'b0, 1'b0, NB_CUR, 1'b0);
      5'd3:  u = mk(OP_RDH, SRC_A, SRC_A, DST_HP, SH0, 1'b0, 1'b0, NB_NEXT, 1'b0);
      5'd4:  u = mk(OP_MUL, SRC_INV, SRC_INV, DST_A, SH0, 1'b0, 1'b0, NB_CUR, 1'b0);
      5'd5:  u = mk(OP_SUB, SRC_HSUM, SRC_HC2, DST_B, SH0, 1'b0, 1'b0, NB_CUR, 1'b0);
      5'd6:  u = mk(OP_MUL, SRC_B, SRC_A, DST_A, SH28, 1'b1, 1'b1, NB_CUR, 1'b0);
      5'd7:  u = mk(OP_DIV, SRC_TWO60, SRC_HC, DST_B, SH0, 1'b0, 1'b0, NB_CUR, 1'b0);
      5'd8:  u = mk(OP_MUL, SRC_B, SRC_B, DST_C, SH32, 1'b0, 1'b0, NB_CUR, 1'b0);
      5'd9:  u = mk(OP_MUL, SRC_C, SRC_B, DST_C, SH32, 1'b0, 1'b0, NB_CUR, 1'b0);
      5'd10: u = mk(OP_MUL, SRC_L6, SRC_C, DST_D, SH40, 1'b0, 1'b0, NB_CUR, 1'b0);
      5'd11: u = mk(OP_MUL, SRC_D, SRC_C, DST_D, SH56, 1'b0, 1'b1, NB_CUR, 1'b0);
      5'd12: u = mk(OP_SUB, SRC_ONE32, SRC_D, DST_D, SH0, 1'b0, 1'b0, NB_CUR, 1'b0);
      5'd13: u = mk(OP_MUL, SRC_D, SRC_C, DST_D, SH32, 1'b1, 1'b1, NB_CUR, 1'b0);
      5'd14: u = mk(OP_DV3, SRC_D, SRC_RECIP3, DST_D, SH0, 1'b1, 1'b0, NB_CUR, 1'b0);
      5'd15: u = mk(OP_SUB, SRC_A, SRC_D, DST_A, SH0, 1'b0, 1'b0, NB_CUR, 1'b0);
      default: u = mk(OP_WRP, SRC_A, SRC_A, DST_A, SH0, 1'b0, 1'b0, NB_CUR, 1'b1);
    endcase
    return u;
  endfunction

  // rate program, one pass per emitted point
  function automatic uop_t emit_uop(logic [4:0] pc);
    uop_t u;
    unique case (pc)
      5'd0:  u = mk(OP_CLR, SRC_A, SRC_A, DST_A, SH0, 1'b0, 1'b0, NB_CUR, 1'b0);
      5'd1:  u = mk(OP_RDH, SRC_A, SRC_A, DST_HM, SH0, 1'b0, 1'b0, NB_PREV, 1'b0);
      5'd2:  u = mk(OP_RDH, SRC_A, SRC_A, DST_HC, SH0, 1'b0, 1'b0, NB_CUR, 1'b0);
      5'd3:  u = mk(OP_RDH, SRC_A, SRC_A, DST_HP, SH0, 1'b0, 1'b0, NB_NEXT, 1'b0);
      5'd4:  u = mk(OP_RDP, SRC_A, SRC_A, DST_PM, SH0, 1'b0, 1'b0, NB_PREV, 1'b0);
      5'd5:  u = mk(OP_RDP, SRC_A, SRC_A, DST_PK, SH0, 1'b0, 1'b0, NB_CUR, 1'b0);
      5'd6:  u = mk(OP_RDP, SRC_A, SRC_A, DST_PN, SH0, 1'b0, 1'b0, NB_NEXT, 1'b0);
      5'd7:  u = mk(OP_SUB, SRC_PN, SRC_PK, DST_A, SH0, 1'b0, 1'b0, NB_CUR, 1'b0);
      5'd8:  u = mk(OP_MUL, SRC_A, SRC_INV, DST_A, SH16, 1'b1, 1'b1, NB_CUR, 1'b0);
      5'd9:  u = mk(OP_SUB, SRC_PK, SRC_PM, DST_B, SH0, 1'b0, 1'b0, NB_CUR, 1'b0);
      5'd10: u = mk(OP_MUL, SRC_B, SRC_INV, DST_B, SH16, 1'b1, 1'b1, NB_CUR, 1'b0);
      5'd11: u = mk(OP_MUL, SRC_MIDP, SRC_MIDP, DST_C, SH0, 1'b0, 1'b0, NB_CUR, 1'b0);
      5'd12: u = mk(OP_MUL, SRC_C, SRC_MIDP, DST_C, SH52, 1'b0, 1'b0, NB_CUR, 1'b0);
      5'd13: u = mk(OP_MUL, SRC_A, SRC_C, DST_A, SH32, 1'b1, 1'b1, NB_CUR, 1'b0);
      5'd14: u = mk(OP_MUL, SRC_MIDM, SRC_MIDM, DST_C, SH0, 1'b0, 1'b0, NB_CUR, 1'b0);
      5'd15: u = mk(OP_MUL, SRC_C, SRC_MIDM, DST_C, SH52, 1'b0, 1'b0, NB_CUR, 1'b0);
      5'd16: u = mk(OP_MUL, SRC_B, SRC_C, DST_B, SH32, 1'b1, 1'b1, NB_CUR, 1'b0);
      5'd17: u = mk(OP_SUB, SRC_A, SRC_B, DST_A, SH0, 1'b0, 1'b0, NB_CUR, 1'b0);
      5'd18: u = mk(OP_MUL, SRC_A, SRC_INV, DST_A, SH24, 1'b1, 1'b1, NB_CUR, 1'b0);
      5'd19: u = mk(OP_NEG, SRC_A, SRC_A, DST_A, SH0, 1'b0, 1'b0, NB_CUR, 1'b0);
      default: u = mk(OP_OUT, SRC_A, SRC_A, DST_A, SH0, 1'b0, 1'b0, NB_CUR, 1'b1);
    endcase
    return u;
  endfunction

endpackage

### hw/rtl/tfrhs_ifs.sv
// Valid/ready channel interfaces for heights in and rates out.
// Depends on nothing; used by the datapath and top level.
interface tfrhs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] height;
  logic        last_point;

  modport source (output valid, output height, output last_point, input ready);
  modport sink   (input valid, input height, input last_point, output ready);
endinterface

interface tfrhs_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] rate;
  logic [5:0]         point_index;
  logic               saturated;
  logic               last_rate;

  modport source (output valid, output rate, output point_index, output saturated,
                  output last_rate, input ready);
  modport sink   (input valid, input rate, input point_index, input saturated,
                  input last_rate, output ready);
endinterface

### hw/rtl/tfrhs_ctrl.sv
// Controller: load counter, per-point program sequencer and neighbour addressing.
// Depends on tfrhs_pkg (micro-op tables, command types).
module tfrhs_ctrl #(
  parameter int MAX_POINTS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_last,
  output logic                in_ready,
  output tfrhs_pkg::cmd_t     cmd,
  input  tfrhs_pkg::status_t  status
);
  import tfrhs_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [2:0] {
    S_LOAD  = 3'b001,
    S_ISSUE = 3'b010,
    S_WAIT  = 3'b100
  } state_t;

  state_t         state, state_next;
  logic           emit, emit_next;
  logic [4:0]     pc, pc_next;
  logic [AW-1:0]  idx, idx_next;
  logic [CW-1:0]  count, count_next;

  uop_t           uop;
  logic           accept;
  logic           room;
  logic           is_last_pt;
  logic [AW-1:0]  prev_addr, next_addr, sel_addr;

  assign uop        = emit ? emit_uop(pc) : press_uop(pc);
  assign in_ready   = (state == S_LOAD);
  assign accept     = in_valid & in_ready;
  assign room       = (count < CW'(MAX_POINTS));
  assign is_last_pt = ((CW'(idx) + CW'(1)) == count);

  // periodic neighbours over the points of this run
  assign prev_addr = (idx == '0) ? AW'(count - CW'(1)) : idx - AW'(1);
  assign next_addr = is_last_pt ? '0 : idx + AW'(1);

  always_comb begin
    unique case (uop.nb)
      NB_PREV: sel_addr = prev_addr;
      NB_NEXT: sel_addr = next_addr;
      default: sel_addr = idx;
    endcase
  end

  // command to the datapath
  always_comb begin
    cmd          = '0;
    cmd.start    = (state == S_ISSUE);
    cmd.load_we  = accept & room;
    cmd.addr     = (state == S_LOAD) ? ADDR_W'(count) : ADDR_W'(sel_addr);
    cmd.pt_index = INDEX_W'(idx);
    cmd.last     = is_last_pt;
    cmd.op       = uop.op;
    cmd.a        = uop.a;
    cmd.b        = uop.b;
    cmd.dst      = uop.dst;
    cmd.sh       = uop.sh;
    cmd.asgn     = uop.asgn;
    cmd.rsgn     = uop.rsgn;
  end

  // sequencing
  always_comb begin
    state_next = state;
    emit_next  = emit;
    pc_next    = pc;
    idx_next   = idx;
    count_next = count;
    unique case (state)
      S_LOAD: begin
        if (accept) begin
          if (room) count_next = count + CW'(1);
          if (in_last) begin
            state_next = S_ISSUE;
            emit_next  = 1'b0;
            pc_next    = '0;
            idx_next   = '0;
          end
        end
      end
      S_ISSUE: state_next = S_WAIT;
      default: begin
        if (status.done) begin
          state_next = S_ISSUE;
          if (!uop.fin) begin
            pc_next = pc + 5'd1;
          end else if (!is_last_pt) begin
            pc_next  = '0;
            idx_next = idx + AW'(1);
          end else if (!emit) begin
            emit_next = 1'b1;
            pc_next   = '0;
            idx_next  = '0;
          end else begin
            state_next = S_LOAD;
            count_next = '0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      emit  <= 1'b0;
      pc    <= '0;
      idx   <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      emit  <= emit_next;
      pc    <= pc_next;
      idx   <= idx_next;
      count <= count_next;
    end
  end

endmodule

### hw/rtl/tfrhs_dp.sv
// Datapath: height and pressure stores, working registers, multi-cycle multiplier,
// serial divider, saturating subtract and the output register.
// Depends on tfrhs_pkg and the channel interfaces.
module tfrhs_dp #(
  parameter int MAX_POINTS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic                          wr_index,
  input  logic [tfrhs_pkg::CFG_W-1:0]   wr_data,
  input  logic [31:0]                   in_height,
  input  tfrhs_pkg::cmd_t               cmd,
  output tfrhs_pkg::status_t            status,
  tfrhs_out_if.source                   rates
);
  import tfrhs_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam logic [6:0] MUL_LAST = 7'd4;
  localparam logic [6:0] DIV_LAST = 7'd64;

  // configuration
  logic [31:0] inv_spacing, precursor_pow6;

  // stores
  logic [31:0] hmem [MAX_POINTS];
  logic [63:0] pmem [MAX_POINTS];
  logic        cmem [MAX_POINTS];
  logic [31:0] hrd;
  logic [63:0] prd;
  logic        crd;

  // working registers
  logic [31:0] hm, hc, hp;
  logic [63:0] pm, pk, pn, reg_a, reg_b, reg_c, reg_d;

  // op in flight
  logic          busy;
  logic [6:0]    cnt;
  op_t           op_q;
  dst_t          dst_q;
  sh_t           sh_q;
  logic          rsgn_q, neg_q;
  logic [AW-1:0] addr_q;
  logic [5:0]    idx_q;
  logic          last_q;
  logic [63:0]   xa, xb;
  logic [127:0]  acc;
  logic [31:0]   rem;
  logic          flag;

  // output register
  logic               out_valid;
  logic signed [63:0] out_rate;
  logic [5:0]         out_index;
  logic               out_sat, out_last;

  logic [63:0] opa, opb;
  logic        fin_now;
  logic [63:0] res;
  logic        res_clip;
  logic        any_zero;
  logic [63:0] q3;

  // operand selection
  function automatic logic [63:0] src_val(src_t s);
    logic [32:0] mid;
    mid = '0;
    unique case (s)
      SRC_A:     return reg_a;
      SRC_B:     return reg_b;
      SRC_C:     return reg_c;
      SRC_D:     return reg_d;
      SRC_PM:    return pm;
      SRC_PK:    return pk;
      SRC_PN:    return pn;
      SRC_HC:    return 64'(hc);
      SRC_INV:   return 64'(inv_spacing);
      SRC_L6:    return 64'(precursor_pow6);
      SRC_HSUM:  return 64'(hp) + 64'(hm);
      SRC_HC2:   return 64'({hc, 1'b0});
      SRC_MIDP: begin
        mid = 33'(hc) + 33'(hp);
        return 64'(mid[32:1]);
      end
      SRC_MIDM: begin
        mid = 33'(hc) + 33'(hm);
        return 64'(mid[32:1]);
      end
      SRC_ONE32: return 64'h1_0000_0000;
      SRC_TWO60: return 64'h1000_0000_0000_0000;
      SRC_THREE: return 64'd3;
      // (2^65 + 1) / 3: reciprocal of three for a divide by multiply
      SRC_RECIP3: return 64'hAAAA_AAAA_AAAA_AAAB;
      default:   return '0;
    endcase
  endfunction

  always_comb begin
    opa = src_val(cmd.a);
    opb = src_val(cmd.b);
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_spacing    <= 32'd877666;
      precursor_pow6 <= 32'd1180591621;
    end else if (wr_en) begin
      if (wr_index == CFG_INV_SPACING) inv_spacing <= wr_data;
      if (wr_index == CFG_PRECURSOR_POW6) precursor_pow6 <= wr_data;
    end
  end

  // height store: written while loading, read by the programs
  always_ff @(posedge clk) begin
    if (cmd.load_we) hmem[cmd.addr[AW-1:0]] <= in_height;
    hrd <= hmem[cmd.addr[AW-1:0]];
  end

  // pressure store with its clip bits
  always_ff @(posedge clk) begin
    if (fin_now && op_q == OP_WRP) begin
      pmem[addr_q] <= (hc == '0) ? '0 : xa;
      cmem[addr_q] <= (hc == '0) ? 1'b0 : flag;
    end
    prd <= pmem[cmd.addr[AW-1:0]];
    crd <= cmem[cmd.addr[AW-1:0]];
  end

  // multiplier partial product
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  always_comb begin
    pa = cnt[1] ? xa[63:32] : xa[31:0];
    pb = cnt[0] ? xb[63:32] : xb[31:0];
    pp = 64'(pa) * 64'(pb);
    unique case ({1'b0, cnt[1]} + {1'b0, cnt[0]})
      2'd0:    pp_sh = {64'd0, pp};
      2'd1:    pp_sh = {32'd0, pp, 32'd0};
      default: pp_sh = {pp, 64'd0};
    endcase
  end

  // divider step
  logic [32:0] rem_sh;
  logic        ge;
  logic [32:0] rem_sub;
  assign rem_sh  = {rem, xa[63]};
  assign ge      = (rem_sh >= {1'b0, xb[31:0]});
  assign rem_sub = rem_sh - {1'b0, xb[31:0]};

  // divide by three: high bits of the reciprocal product
  assign q3 = {1'b0, acc[127:65]};

  // multiply finish: shift, saturate, sign
  logic [5:0]   sh_amt;
  logic [127:0] shifted;
  logic         m_ovf;
  logic [63:0]  m_u, m_res;
  logic         m_clip;
  always_comb begin
    unique case (sh_q)
      SH0:     sh_amt = 6'd0;
      SH16:    sh_amt = 6'd16;
      SH24:    sh_amt = 6'd24;
      SH28:    sh_amt = 6'd28;
      SH32:    sh_amt = 6'd32;
      SH40:    sh_amt = 6'd40;
      SH52:    sh_amt = 6'd52;
      default: sh_amt = 6'd56;
    endcase
    shifted = acc >> sh_amt;
    m_ovf   = (shifted[127:64] != '0);
    m_u     = m_ovf ? '1 : shifted[63:0];
    m_res   = m_u;
    m_clip  = m_ovf;
    if (rsgn_q) begin
      if (!neg_q) begin
        if (m_u[63]) begin
          m_res  = S64_MAX;
          m_clip = 1'b1;
        end
      end else if (m_u[63]) begin
        m_res = S64_MIN;
        if (m_u[62:0] != '0) m_clip = 1'b1;
      end else begin
        m_res = -m_u;
      end
    end
  end

  // saturating subtract
  logic [64:0] d65;
  logic        s_ovf;
  assign d65   = {xa[63], xa} - {xb[63], xb};
  assign s_ovf = d65[64] ^ d65[63];

  // result of the op that finishes now
  always_comb begin
    res      = '0;
    res_clip = 1'b0;
    unique case (op_q)
      OP_RDH: res = 64'(hrd);
      OP_RDP: begin
        res      = prd;
        res_clip = crd;
      end
      OP_MUL: begin
        res      = m_res;
        res_clip = m_clip;
      end
      OP_DIV: res = neg_q ? -xa : xa;
      OP_DV3: res = neg_q ? -q3 : q3;
      OP_SUB: begin
        res      = s_ovf ? (d65[64] ? S64_MIN : S64_MAX) : d65[63:0];
        res_clip = s_ovf;
      end
      OP_NEG: begin
        res      = (xa == S64_MIN) ? S64_MAX : -xa;
        res_clip = (xa == S64_MIN);
      end
      default: res = xa;
    endcase
  end

  always_comb begin
    unique case (op_q)
      OP_MUL, OP_DV3: fin_now = busy & (cnt == MUL_LAST);
      OP_DIV:  fin_now = busy & (cnt == DIV_LAST);
      OP_OUT:  fin_now = busy & (!out_valid | rates.ready);
      default: fin_now = busy;
    endcase
  end

  assign status.done = fin_now;
  assign any_zero    = (hm == '0) | (hc == '0) | (hp == '0);

  // op control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd.start) begin
      busy <= 1'b1;
    end else if (fin_now) begin
      busy <= 1'b0;
    end
  end

  // operand capture and iteration
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cnt    <= '0;
      op_q   <= cmd.op;
      dst_q  <= cmd.dst;
      sh_q   <= cmd.sh;
      rsgn_q <= cmd.rsgn;
      neg_q  <= cmd.asgn & opa[63];
      addr_q <= cmd.addr[AW-1:0];
      idx_q  <= cmd.pt_index;
      last_q <= cmd.last;
      xa     <= (cmd.asgn & opa[63]) ? -opa : opa;
      xb     <= opb;
      acc    <= '0;
      rem    <= '0;
    end else if (busy) begin
      cnt <= cnt + 7'd1;
      if ((op_q == OP_MUL || op_q == OP_DV3) && cnt < MUL_LAST) acc <= acc + pp_sh;
      if (op_q == OP_DIV && cnt < DIV_LAST) begin
        rem <= ge ? rem_sub[31:0] : rem_sh[31:0];
        xa  <= {xa[62:0], ge};
      end
    end
  end

  // working register writes and clip flag
  always_ff @(posedge clk) begin
    if (fin_now) begin
      if (op_q == OP_CLR) flag <= 1'b0;
      else flag <= flag | res_clip;
      if (op_q == OP_RDH || op_q == OP_RDP || op_q == OP_MUL || op_q == OP_DIV ||
          op_q == OP_DV3 || op_q == OP_SUB || op_q == OP_NEG) begin
        unique case (dst_q)
          DST_A:   reg_a <= res;
          DST_B:   reg_b <= res;
          DST_C:   reg_c <= res;
          DST_D:   reg_d <= res;
          DST_HM:  hm <= res[31:0];
          DST_HC:  hc <= res[31:0];
          DST_HP:  hp <= res[31:0];
          DST_PM:  pm <= res;
          DST_PK:  pk <= res;
          default: pn <= res;
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_now && op_q == OP_OUT) begin
      out_valid <= 1'b1;
    end else if (rates.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_now && op_q == OP_OUT) begin
      out_rate  <= any_zero ? '0 : xa;
      out_sat   <= any_zero | flag;
      out_index <= idx_q;
      out_last  <= last_q;
    end
  end

  assign rates.valid       = out_valid;
  assign rates.rate        = out_rate;
  assign rates.point_index = out_index;
  assign rates.saturated   = out_sat;
  assign rates.last_rate   = out_last;

endmodule

### hw/rtl/thin_film_rhs_stencil_top.sv
// Top level of the thin film rate stencil: controller plus datapath.
// Depends on tfrhs_pkg, tfrhs_ifs, tfrhs_ctrl and tfrhs_dp.
//
//   channel   dir   payload                                   handshake
//   heights   in    height[31:0], last_point                  valid/ready
//   rates     out   rate[63:0], point_index[5:0], saturated,  valid/ready
//                   last_rate
//   config    in    wr_index, wr_data[31:0]                   wr_en, no wait
//
// Loading accepts one height per cycle. The point marked last starts two passes over
// the n stored points on one shared multiplier and serial divider: one for pressure
// (the 64-step division of 1/H dominates) and one for the rates. No clearing pass
// after reset. Heights are refused during both passes; a stalled rates channel holds
// the sequencer at the point's output step.
module thin_film_rhs_stencil_top #(
  parameter int MAX_POINTS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic                        wr_index,
  input  logic [tfrhs_pkg::CFG_W-1:0] wr_data,
  tfrhs_in_if.sink                    heights,
  tfrhs_out_if.source                 rates
);
  import tfrhs_pkg::*;

  cmd_t    cmd;
  status_t status;

  tfrhs_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (heights.valid),
    .in_last  (heights.last_point),
    .in_ready (heights.ready),
    .cmd      (cmd),
    .status   (status)
  );

  tfrhs_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .in_height (heights.height),
    .cmd       (cmd),
    .status    (status),
    .rates     (rates)
  );

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for thin_film_rhs_stencil_top: profiles in, dH/dt rates out.
// Depends on tfrhs_pkg, tfrhs_ifs and the top level; rates are checked against a local
// fixed-point model of the stencil.
module tb_top;
  import tfrhs_pkg::*;

  localparam int  NPTS_MAX   = 64;
  localparam int  CYCLE_MAX  = 3_000_000;
  localparam int  RAND_TARGET = 360;
  localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] H_ONE  = 32'h1000_0000;

  typedef struct {
    logic signed [63:0] rate;
    logic [5:0]         idx;
    bit                 sat;
    bit                 lst;
  } rate_exp_t;

  // directed stimulus row; typed rows carry the rate of a one-point profile
  typedef struct {
    logic [31:0]        height;
    bit                 last;
    bit                 typed;
    logic signed [63:0] rate;
    bit                 sat;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic wr_index = CFG_INV_SPACING;
  logic [CFG_W-1:0] wr_data = '0;

  tfrhs_in_if  heights ();
  tfrhs_out_if rates ();

  thin_film_rhs_stencil_top dut (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .heights(heights.sink), .rates(rates.source)
  );

  always #5 clk = ~clk;

  // model state
  logic [31:0] inv_dx = 32'd877666;
  logic [31:0] film_l6 = 32'd1180591621;
  logic [31:0] profile [NPTS_MAX];
  int          n_loaded = 0;
  rate_exp_t   rates_due [$];

  int  errors = 0;
  bit  no_idle = 1'b0;
  bit  hold_go = 1'b0;
  int  hold_cnt = 0;
  longint cycles = 0;

  // ---------------- fixed-point model ----------------
  function automatic logic [63:0] shr_sat(logic [127:0] w, int sh, inout bit c);
    if ((w >> (64 + sh)) != 0) begin
      c = 1'b1;
      return U64_MAX;
    end
    return w[sh +: 64];
  endfunction

  function automatic logic signed [63:0] smul_sat(logic signed [63:0] a, logic [63:0] b,
                                                  int sh, inout bit c);
    logic [63:0] ma;
    logic [63:0] m;
    ma = a[63] ? -a : a;
    m = shr_sat({64'd0, ma} * {64'd0, b}, sh, c);
    if (!a[63]) begin
      if (m[63]) begin
        c = 1'b1;
        return S64_MAX;
      end
      return m;
    end
    if (m > S64_MIN) begin
      c = 1'b1;
      return S64_MIN;
    end
    return -m;
  endfunction

  function automatic logic signed [63:0] ssub_sat(logic signed [63:0] a,
                                                  logic signed [63:0] b, inout bit c);
    logic signed [64:0] d;
    d = {a[63], a} - {b[63], b};
    if (d > $signed({1'b0, S64_MAX})) begin
      c = 1'b1;
      return S64_MAX;
    end
    if (d < $signed({1'b1, S64_MIN})) begin
      c = 1'b1;
      return S64_MIN;
    end
    return d[63:0];
  endfunction

  function automatic logic signed [63:0] disjoining(logic [31:0] hm, logic [31:0] hc,
                                                    logic [31:0] hp, inout bit c);
    logic [63:0] idx2, r, r2, r3, a, t;
    longint s, curv, v, w;
    idx2 = {32'd0, inv_dx} * {32'd0, inv_dx};
    s = longint'({32'd0, hp}) - 2 * longint'({32'd0, hc}) + longint'({32'd0, hm});
    curv = smul_sat(s, idx2, 28, c);
    r  = (64'd1 << 60) / {32'd0, hc};
    r2 = shr_sat({64'd0, r} * {64'd0, r}, 32, c);
    r3 = shr_sat({64'd0, r2} * {64'd0, r}, 32, c);
    a  = shr_sat({96'd0, film_l6} * {64'd0, r3}, 40, c);
    t  = shr_sat({64'd0, a} * {64'd0, r3}, 56, c);
    if (t[63]) begin
      c = 1'b1;
      t = S64_MAX;
    end
    v = ssub_sat(64'sd1 <<< 32, t, c);
    w = smul_sat(v, r3, 32, c);
    return ssub_sat(curv, w / 3, c);
  endfunction

  function automatic logic [63:0] mid_cube(logic [31:0] a, logic [31:0] b, inout bit c);
    logic [63:0] m;
    m = ({32'd0, a} + {32'd0, b}) >> 1;
    return shr_sat({64'd0, m * m} * {64'd0, m}, 52, c);
  endfunction

  // one accepted height; a closing point queues the rates of the whole profile
  task automatic load_point(logic [31:0] h, bit last);
    logic signed [63:0] pr [NPTS_MAX];
    bit                 pc [NPTS_MAX];
    int n, pv, nx;
    bit c;
    logic signed [63:0] gp, gm, fp, fm, r, rt;
    rate_exp_t e;
    if (n_loaded < NPTS_MAX) begin
      profile[n_loaded] = h;
      n_loaded++;
    end
    if (!last) return;
    n = n_loaded;
    for (int i = 0; i < n; i++) begin
      pv = (i == 0) ? n - 1 : i - 1;
      nx = (i + 1 == n) ? 0 : i + 1;
      c = 1'b0;
      pr[i] = 0;
      if (profile[i] != 0) pr[i] = disjoining(profile[pv], profile[i], profile[nx], c);
      pc[i] = c;
    end
    for (int k = 0; k < n; k++) begin
      pv = (k == 0) ? n - 1 : k - 1;
      nx = (k + 1 == n) ? 0 : k + 1;
      c = pc[pv] | pc[k] | pc[nx];
      rt = 0;
      if (profile[pv] == 0 || profile[k] == 0 || profile[nx] == 0) begin
        c = 1'b1;
      end else begin
        gp = smul_sat(ssub_sat(pr[nx], pr[k], c), inv_dx, 16, c);
        gm = smul_sat(ssub_sat(pr[k], pr[pv], c), inv_dx, 16, c);
        fp = smul_sat(gp, mid_cube(profile[k], profile[nx], c), 32, c);
        fm = smul_sat(gm, mid_cube(profile[k], profile[pv], c), 32, c);
        r  = smul_sat(ssub_sat(fp, fm, c), inv_dx, 24, c);
        if (r == S64_MIN) begin
          c = 1'b1;
          rt = S64_MAX;
        end else begin
          rt = -r;
        end
      end
      e.rate = rt;
      e.idx = k[5:0];
      e.sat = c;
      e.lst = (k + 1 == n);
      rates_due.push_back(e);
    end
    n_loaded = 0;
  endtask

  // ---------------- drivers ----------------
  // offer one height and wait for its transfer
  task automatic send_point(logic [31:0] h, bit last);
    if (!no_idle && $urandom_range(0, 99) < 12) begin
      heights.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    heights.valid      <= 1'b1;
    heights.height     <= h;
    heights.last_point <= last;
    @(posedge clk);
    while (!heights.ready) @(posedge clk);
    load_point(h, last);
  endtask

  task automatic drain;
    heights.valid <= 1'b0;
    while (rates_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    if (idx == CFG_INV_SPACING) inv_dx = val;
    else film_l6 = val;
  endtask

  function automatic logic [31:0] pick_height();
    int sel;
    sel = $urandom_range(0, 39);
    if (sel == 0) return 32'd0;
    if (sel < 5) return $urandom;
    if (sel < 7) return $urandom_range(1, 255);
    return H_ONE - 32'h0800_0000 + $urandom_range(0, 32'h1000_0000);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial rates.ready = 1'b0;
  always @(posedge clk) begin
    if (hold_go) begin
      hold_go  = 1'b0;
      hold_cnt = 2500;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      rates.ready <= 1'b0;
    end else begin
      rates.ready <= no_idle || ($urandom_range(0, 99) >= 12);
    end
  end

  // check every rate transfer against the oldest expectation
  always @(posedge clk) begin
    rate_exp_t e;
    if (!rst && rates.valid && rates.ready) begin
      if (rates_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected rate: expected none, actual rate=%h idx=%0d",
                 $time, rates.rate, rates.point_index);
      end else begin
        e = rates_due.pop_front();
        if (rates.rate !== e.rate || rates.point_index !== e.idx ||
            rates.saturated !== e.sat || rates.last_rate !== e.lst) begin
          errors++;
          $display("%0t: rate mismatch: expected rate=%h idx=%0d sat=%0b last=%0b",
                   $time, e.rate, e.idx, e.sat, e.lst);
          $display("%0t:                actual   rate=%h idx=%0d sat=%0b last=%0b",
                   $time, rates.rate, rates.point_index, rates.saturated,
                   rates.last_rate);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_MAX) begin
      $display("** thin_film_rhs_stencil_top: FAILED **");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  dir_row_t dir_rows [] = '{
    '{32'h0000_0000, 1, 1, 64'sd0, 1},   // zero height alone
    '{H_ONE,         1, 1, 64'sd0, 0},   // flat film of unit height
    '{32'hFFFF_FFFF, 1, 1, 64'sd0, 0},   // tallest height
    '{32'h0000_0001, 1, 1, 64'sd0, 1},   // thinnest height clips 1/H^3
    '{H_ONE,         0, 0, 64'sd0, 0},   // two-point profile
    '{32'h1800_0000, 1, 0, 64'sd0, 0},
    '{H_ONE,         0, 0, 64'sd0, 0},   // zero height inside a profile
    '{32'h0000_0000, 0, 0, 64'sd0, 0},
    '{32'h1333_3333, 1, 0, 64'sd0, 0},
    '{32'h0CCC_CCCD, 0, 0, 64'sd0, 0},   // mixed extremes
    '{32'hFFFF_FFFF, 0, 0, 64'sd0, 0},
    '{32'h0000_0001, 0, 0, 64'sd0, 0},
    '{32'h1000_0000, 0, 0, 64'sd0, 0},
    '{32'h8000_0000, 1, 0, 64'sd0, 0},
    '{32'h0800_0000, 0, 0, 64'sd0, 0},   // smooth ramp
    '{32'h0C00_0000, 0, 0, 64'sd0, 0},
    '{32'h1000_0000, 0, 0, 64'sd0, 0},
    '{32'h1400_0000, 1, 0, 64'sd0, 0}
  };

  logic [31:0] cfg_inv [6] = '{32'h0001_0000, 32'hFFFF_FFFF, 32'd0, 32'd877666,
                               32'h0004_0000, 32'd0};
  logic [31:0] cfg_l6  [6] = '{32'd0, 32'hFFFF_FFFF, 32'd1180591621, 32'hFFFF_FFFF,
                               32'd0, 32'd0};

  initial begin
    int npts, big_left, per_phase;
    heights.valid = 1'b0;
    heights.height = '0;
    heights.last_point = 1'b0;
    big_left = 3;
    per_phase = RAND_TARGET / 6;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed profiles under reset settings
    foreach (dir_rows[i]) begin
      send_point(dir_rows[i].height, dir_rows[i].last);
      if (dir_rows[i].typed) begin
        rates_due[rates_due.size() - 1].rate = dir_rows[i].rate;
        rates_due[rates_due.size() - 1].sat  = dir_rows[i].sat;
      end
    end
    drain();

    // random profiles over several register settings
    for (int ph = 0; ph < 6; ph++) begin
      cfg_inv[ph] = (ph == 5) ? $urandom : cfg_inv[ph];
      cfg_l6[ph]  = (ph == 5) ? $urandom : cfg_l6[ph];
      write_reg(CFG_INV_SPACING, cfg_inv[ph]);
      write_reg(CFG_PRECURSOR_POW6, cfg_l6[ph]);
      no_idle = (ph == 3);
      if (ph == 1) hold_go = 1'b1;
      for (int done_ph = 0; done_ph < per_phase; done_ph += npts) begin
        if (big_left > 0 && $urandom_range(0, 11) == 0) begin
          npts = $urandom_range(62, 68);   // fill the store, sometimes past it
          big_left--;
        end else begin
          npts = $urandom_range(1, 8);
        end
        for (int k = 0; k < npts; k++) send_point(pick_height(), k == npts - 1);
        if (ph == 2 && done_ph == 0) drain();
      end
      drain();
    end
    no_idle = 1'b0;

    while (rates_due.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && rates_due.size() == 0) begin
      $display("** thin_film_rhs_stencil_top: PASSED **");
    end else begin
      $display("** thin_film_rhs_stencil_top: FAILED **");
    end
    $finish;
  end

endmodule
